>>> hw/rtl/curvature_speed_limit_core_assert.svh
// ----------------------------------------------------------------------------
// Curvature speed limit assertion macros
// Shared property wrappers for the checker of the curvature speed limit core.
// ----------------------------------------------------------------------------
`ifndef CURVATURE_SPEED_LIMIT_CORE_ASSERT_SVH
`define CURVATURE_SPEED_LIMIT_CORE_ASSERT_SVH

// Checked only while reset is low.
`define CSL_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("curvature speed limit core: assertion failed");

// Checked on every edge, reset included.
`define CSL_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("curvature speed limit core: assertion failed");

`endif

>>> hw/rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// Curvature speed limit package
// Stage types, step functions and register indexes of the speed limit core.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

   localparam int DIV_STAGES  = 32;
   localparam int SQRT_STAGES = 16;
   localparam int ACCEL_W     = 24;
   localparam int KAPPA_W     = 24;
   localparam int SPEED_W     = 16;
   localparam int QUOT_W      = 32;
   localparam int ROOT_REM_W  = 18;
   localparam int ADDR_W      = 4;

   typedef enum logic [1:0] {
      REG_MIN_SPEED   = 2'd0,
      REG_MAX_SPEED   = 2'd1,
      REG_ACCEL_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KAPPA_W-1:0] rem;
      logic [QUOT_W-1:0]  quot;
      logic [KAPPA_W-1:0] kappa;
      logic               straight;
      logic               sat;
   } div_state_type;

   typedef struct packed {
      logic [QUOT_W-1:0]     rad;
      logic [ROOT_REM_W-1:0] rem;
      logic [SPEED_W-1:0]    root;
      logic                  straight;
      logic                  sat;
   } sqrt_state_type;

   // One restoring division step: one quotient bit.
   function automatic div_state_type div_step(div_state_type s, logic dbit);
      logic [KAPPA_W:0] trial;
      logic [KAPPA_W:0] divisor;
      div_state_type    r;
      r       = s;
      trial   = {s.rem, dbit};
      divisor = {1'b0, s.kappa};
      if (trial >= divisor) begin
         r.rem  = KAPPA_W'(trial - divisor);
         r.quot = {s.quot[QUOT_W-2:0], 1'b1};
      end else begin
         r.rem  = trial[KAPPA_W-1:0];
         r.quot = {s.quot[QUOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One digit-by-digit square root step: one root bit.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      logic [ROOT_REM_W+1:0] cur;
      logic [ROOT_REM_W+1:0] trial;
      sqrt_state_type        r;
      r     = s;
      cur   = {s.rem, s.rad[QUOT_W-1:QUOT_W-2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[QUOT_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = ROOT_REM_W'(cur - trial);
         r.root = {s.root[SPEED_W-2:0], 1'b1};
      end else begin
         r.rem  = cur[ROOT_REM_W-1:0];
         r.root = {s.root[SPEED_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/curvature_speed_limit_core.sv
// Path: an accepted transfer moves through the div_ff stages, the sqrt_ff stages and speed_ff to rsp_speed_limit.
// Throughput: one item per cycle; 32 quotient-bit stages and 16 root-bit stages
// each finish one bit per cycle, and the whole pipeline holds while a result waits
// with rsp_ready low.
// Reset clears the valid bits of every stage and all three registers to zero.
// ----------------------------------------------------------------------------
// Curvature speed limit core
// Turns a path curvature into a clamped speed limit, sqrt(accel * 2^20 / curvature).
// ----------------------------------------------------------------------------
`default_nettype none

module curvature_speed_limit_core
   import csl_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KAPPA_W-1:0]  req_curvature,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SPEED_W-1:0]       rsp_speed_limit,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [SPEED_W-1:0]  min_speed_ff;
   logic [SPEED_W-1:0]  max_speed_ff;
   logic [ACCEL_W-1:0]  accel_limit_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   div_state_type       div_ff [0:DIV_STAGES];
   div_state_type       div_in [0:DIV_STAGES];
   logic                div_valid_ff [0:DIV_STAGES];
   sqrt_state_type      sqrt_ff [0:SQRT_STAGES-1];
   sqrt_state_type      sqrt_in [0:SQRT_STAGES-1];
   logic                sqrt_valid_ff [0:SQRT_STAGES-1];
   sqrt_state_type      sqrt_start;
   logic [QUOT_W-1:0]   dividend_low;
   logic [SPEED_W-1:0]  speed_in;
   logic [SPEED_W-1:0]  speed_ff;
   logic                out_valid_ff;
   logic                advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff   <= '0;
         max_speed_ff   <= '0;
         accel_limit_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MIN_SPEED:   min_speed_ff   <= csr_pwdata[SPEED_W-1:0];
            REG_MAX_SPEED:   max_speed_ff   <= csr_pwdata[SPEED_W-1:0];
            REG_ACCEL_LIMIT: accel_limit_ff <= csr_pwdata[ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MIN_SPEED:   csr_prdata = 32'(min_speed_ff);
         REG_MAX_SPEED:   csr_prdata = 32'(max_speed_ff);
         REG_ACCEL_LIMIT: csr_prdata = 32'(accel_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // The dividend is accel_limit * 2^20; its top bits seed the remainder.
   assign dividend_low = {accel_limit_ff[11:0], 20'b0};

   always_comb begin
      div_in[0].rem      = KAPPA_W'(accel_limit_ff[ACCEL_W-1:12]);
      div_in[0].quot     = '0;
      div_in[0].kappa    = req_curvature;
      div_in[0].straight = (req_curvature <= KAPPA_W'(1));
      div_in[0].sat      = ({12'b0, accel_limit_ff} >= {req_curvature, 12'b0});
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_in[i+1] = div_step(div_ff[i], dividend_low[DIV_STAGES-1-i]);
      end
      sqrt_start.rad      = div_ff[DIV_STAGES].quot;
      sqrt_start.rem      = '0;
      sqrt_start.root     = '0;
      sqrt_start.straight = div_ff[DIV_STAGES].straight;
      sqrt_start.sat      = div_ff[DIV_STAGES].sat;
      sqrt_in[0] = sqrt_step(sqrt_start);
      for (int j = 1; j < SQRT_STAGES; j++) begin
         sqrt_in[j] = sqrt_step(sqrt_ff[j-1]);
      end
   end

   always_comb begin
      if (sqrt_ff[SQRT_STAGES-1].sat) begin
         speed_in = '1;
      end else begin
         speed_in = sqrt_ff[SQRT_STAGES-1].root;
      end
      if (speed_in < min_speed_ff) begin
         speed_in = min_speed_ff;
      end
      if (speed_in > max_speed_ff) begin
         speed_in = max_speed_ff;
      end
      if (sqrt_ff[SQRT_STAGES-1].straight) begin
         speed_in = max_speed_ff;
      end
      if (max_speed_ff == '0) begin
         speed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_ff[i] <= div_in[i];
         end
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sqrt_ff[j] <= sqrt_in[j];
         end
         speed_ff <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sqrt_valid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= req_valid;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
         sqrt_valid_ff[0] <= div_valid_ff[DIV_STAGES];
         for (int j = 1; j < SQRT_STAGES; j++) begin
            sqrt_valid_ff[j] <= sqrt_valid_ff[j-1];
         end
         out_valid_ff <= sqrt_valid_ff[SQRT_STAGES-1];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_speed_limit = speed_ff;

endmodule

`default_nettype wire

>>> hw/rtl/csl_core_checker.sv
// ----------------------------------------------------------------------------
// Curvature speed limit port checker
// Watches the ports of the speed limit core over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "curvature_speed_limit_core_assert.svh"

module csl_core_checker
   import csl_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SPEED_W-1:0]  rsp_speed_limit,
   input wire logic                csr_pready
);

   `CSL_ASSERT(rsp_holds_when_stalled, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_limit))
   `CSL_ASSERT(req_ready_follows_rsp, req_ready == (!rsp_valid || rsp_ready))
   `CSL_ASSERT(csr_always_ready, csr_pready)
   `CSL_ASSERT_ALWAYS(no_rsp_after_reset, $past(reset) |-> !rsp_valid)

endmodule

bind curvature_speed_limit_core csl_core_checker u_csl_core_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curvature speed limit core testbench
// Drives curvature samples through the valid/ready request channel, under
// several speed windows and acceleration limits set over the register port,
// and checks each speed limit against a typed value or an independent model
// of the divide, square root, saturate and clamp.
// ----------------------------------------------------------------------------

module tb;
   import csl_pkg::*;

   localparam int unsigned UNMAPPED_INDEX = int'(REG_ACCEL_LIMIT) + 1;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int STEADY_ITEMS = 200;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [SPEED_W-1:0] min_speed;
      logic [SPEED_W-1:0] max_speed;
      logic [ACCEL_W-1:0] accel;
      logic [KAPPA_W-1:0] kappa;
      logic               typed;
      logic [SPEED_W-1:0] speed;
   } probe_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [KAPPA_W-1:0] req_curvature;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [SPEED_W-1:0] rsp_speed_limit;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   logic [SPEED_W-1:0] min_speed_cfg;
   logic [SPEED_W-1:0] max_speed_cfg;
   logic [ACCEL_W-1:0] accel_cfg;

   logic [SPEED_W-1:0] speed_expected[$];
   probe_type          probes[$];
   int                 fail_count;
   int unsigned        req_idle_pct;
   int unsigned        rsp_idle_pct;
   bit                 steady;

   curvature_speed_limit_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_curvature    (req_curvature),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speed_limit  (rsp_speed_limit),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [SPEED_W-1:0] limit_speed(logic [KAPPA_W-1:0] kappa);
      logic [ACCEL_W+19:0] quot;
      logic [21:0]         root;
      logic [21:0]         trial;
      logic [SPEED_W-1:0]  speed;
      if (max_speed_cfg == '0) return '0;
      if (kappa <= 1) return max_speed_cfg;
      quot = {accel_cfg, 20'd0} / (ACCEL_W + 20)'(kappa);
      root = '0;
      for (int b = 21; b >= 0; b--) begin
         trial = root | (22'd1 << b);
         if (46'(trial) * 46'(trial) <= 46'(quot)) root = trial;
      end
      speed = (root > 22'(16'hFFFF)) ? 16'hFFFF : root[SPEED_W-1:0];
      if (speed < min_speed_cfg) speed = min_speed_cfg;
      if (speed > max_speed_cfg) speed = max_speed_cfg;
      return speed;
   endfunction

   task automatic csr_write(input int unsigned index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (index)
         REG_MIN_SPEED: min_speed_cfg = data[SPEED_W-1:0];
         REG_MAX_SPEED: max_speed_cfg = data[SPEED_W-1:0];
         REG_ACCEL_LIMIT: accel_cfg = data[ACCEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input int unsigned index, output logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'(index * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [31:0] value;
      logic [31:0] want;
      string       name;
      for (int i = 0; i <= int'(REG_ACCEL_LIMIT); i++) begin
         csr_read(i, value);
         case (i)
            REG_MIN_SPEED: begin
               want = 32'(min_speed_cfg);
               name = "min_speed";
            end
            REG_MAX_SPEED: begin
               want = 32'(max_speed_cfg);
               name = "max_speed";
            end
            default: begin
               want = 32'(accel_cfg);
               name = "accel_limit";
            end
         endcase
         if (value !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, value);
            fail_count++;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (speed_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic [SPEED_W-1:0] min_s,
                               input logic [SPEED_W-1:0] max_s,
                               input logic [ACCEL_W-1:0] accel);
      drain();
      csr_write(REG_MIN_SPEED, {16'($urandom), min_s});
      csr_write(REG_MAX_SPEED, {16'($urandom), max_s});
      csr_write(REG_ACCEL_LIMIT, {8'($urandom), accel});
      csr_write(UNMAPPED_INDEX, $urandom);
      check_registers();
   endtask

   task automatic send_curvature(input logic [KAPPA_W-1:0] kappa, input logic typed,
                                 input logic [SPEED_W-1:0] typed_speed);
      req_valid     <= 1'b1;
      req_curvature <= kappa;
      do @(posedge clock); while (!req_ready);
      speed_expected.push_back(typed ? typed_speed : limit_speed(kappa));
      if (!steady && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic add_probe(input logic [SPEED_W-1:0] min_s, input logic [SPEED_W-1:0] max_s,
                            input logic [ACCEL_W-1:0] accel, input logic [KAPPA_W-1:0] kappa,
                            input logic typed, input logic [SPEED_W-1:0] speed);
      probe_type p;
      p.min_speed = min_s;
      p.max_speed = max_s;
      p.accel     = accel;
      p.kappa     = kappa;
      p.typed     = typed;
      p.speed     = speed;
      probes.push_back(p);
   endtask

   always @(posedge clock) begin : check_speed
      logic [SPEED_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (speed_expected.size() == 0) begin
            $error("speed_limit: unexpected transfer, actual %0h", rsp_speed_limit);
            fail_count++;
         end else begin
            want = speed_expected.pop_front();
            if (rsp_speed_limit !== want) begin
               $error("speed_limit: expected %0h, actual %0h", want, rsp_speed_limit);
               fail_count++;
            end
         end
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      logic [SPEED_W-1:0] min_s;
      logic [SPEED_W-1:0] max_s;
      logic [ACCEL_W-1:0] accel;
      logic [KAPPA_W-1:0] kappa;
      probe_type          p;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_curvature <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      min_speed_cfg = '0;
      max_speed_cfg = '0;
      accel_cfg     = '0;
      fail_count    = 0;
      req_idle_pct  = 20;
      rsp_idle_pct  = 20;
      steady        = 1'b0;

      add_probe(16'h0000, 16'h0000, 24'h000000, 24'h000000, 1'b1, 16'h0000);
      add_probe(16'h0000, 16'h0000, 24'h000000, 24'hFFFFFF, 1'b1, 16'h0000);
      add_probe(16'h0000, 16'h0000, 24'h000000, 24'h000002, 1'b1, 16'h0000);
      add_probe(16'h0100, 16'hFFFF, 24'h000000, 24'h000000, 1'b1, 16'hFFFF);
      add_probe(16'h0100, 16'hFFFF, 24'h000000, 24'h000001, 1'b1, 16'hFFFF);
      add_probe(16'h0100, 16'hFFFF, 24'h000000, 24'h000002, 1'b1, 16'h0100);
      add_probe(16'h0100, 16'hFFFF, 24'h000000, 24'hFFFFFF, 1'b1, 16'h0100);
      add_probe(16'h0000, 16'hFFFF, 24'hFFFFFF, 24'h000002, 1'b1, 16'hFFFF);
      add_probe(16'h0000, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'h0400);
      add_probe(16'h0000, 16'hFFFF, 24'hFFFFFF, 24'h800000, 1'b0, 16'h0000);
      add_probe(16'h0000, 16'hFFFF, 24'hFFFFFF, 24'h000ABC, 1'b0, 16'h0000);
      add_probe(16'h2000, 16'h1000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'h1000);
      add_probe(16'h2000, 16'h1000, 24'hFFFFFF, 24'h000002, 1'b1, 16'h1000);
      add_probe(16'h2000, 16'h1000, 24'hFFFFFF, 24'h000001, 1'b1, 16'h1000);
      add_probe(16'h0000, 16'h0001, 24'h000001, 24'hFFFFFF, 1'b1, 16'h0000);
      add_probe(16'h0000, 16'h0001, 24'h000001, 24'h000002, 1'b1, 16'h0001);
      add_probe(16'hFFFF, 16'hFFFF, 24'h000001, 24'h123456, 1'b1, 16'hFFFF);
      add_probe(16'h0000, 16'hFFFF, 24'h010000, 24'h100000, 1'b1, 16'h0100);
      add_probe(16'h0000, 16'hFFFF, 24'h010000, 24'h400000, 1'b1, 16'h0080);
      add_probe(16'h0000, 16'hFFFF, 24'h010000, 24'h555555, 1'b0, 16'h0000);
      add_probe(16'h0000, 16'hFFFF, 24'h010000, 24'h000003, 1'b0, 16'h0000);
      add_probe(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000000, 1'b1, 16'h0000);
      add_probe(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000002, 1'b1, 16'h0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();

      foreach (probes[i]) begin
         p = probes[i];
         if (p.min_speed != min_speed_cfg || p.max_speed != max_speed_cfg ||
             p.accel != accel_cfg) begin
            apply_config(p.min_speed, p.max_speed, p.accel);
         end
         send_curvature(p.kappa, p.typed, p.speed);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               min_s = 16'h0000;
               max_s = 16'hFFFF;
               accel = 24'hFFFFFF;
            end
            1: begin
               min_s = 16'($urandom);
               max_s = 16'h0000;
               accel = 24'($urandom);
            end
            default: begin
               min_s = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'h0800));
               max_s = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
               accel = 24'($urandom >> $urandom_range(8, 31));
            end
         endcase
         apply_config(min_s, max_s, accel);
         req_idle_pct = $urandom_range(0, 2) * 15;
         rsp_idle_pct = $urandom_range(0, 2) * 15;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == RANDOM_PHASES - 1 && n == PHASE_ITEMS - STEADY_ITEMS + 25) begin
               steady = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) begin
               kappa = 24'($urandom_range(0, 2));
            end else begin
               kappa = 24'($urandom) >> $urandom_range(0, 23);
            end
            send_curvature(kappa, 1'b0, '0);
         end
      end

      steady = 1'b1;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
